// ===== hdl/sws_pkg.sv =====
// Package for the stack with search and remove.
// Holds the sizes, the operation and status codes and the cell control struct.
// No dependencies.
`default_nettype none

package sws_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int POS_W      = $clog2(DEPTH);

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_REMOVE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic cmp_en;
        logic push;
        logic pop;
        logic remove;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/stack_with_search_and_remove.sv =====
// Top level of the stack with search and remove: control, count and result register.
// Builds the row of sws_cell instances. Depends on sws_pkg and sws_cell.
//
//   channel  ports                                                 direction
//   s_       s_valid s_ready s_func s_value                        in
//   m_       m_valid m_ready m_result_value m_found m_position     out
//            m_entry_count m_status
//
// Each beat has a compare step, in which every cell compares its word with the key,
// and a commit step, in which the cells shift and the result register loads.
// The commit step waits while a result is held and not taken; a new beat is
// accepted as soon as the previous one has reached the result register.
// Reset empties the stack at once; no clearing pass is needed.
`default_nettype none

module stack_with_search_and_remove
    import sws_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_func,
    input  wire logic [VALUE_W-1:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [VALUE_W-1:0]      m_result_value,
    output logic                    m_found,
    output logic [3:0]              m_position,
    output logic [4:0]              m_entry_count,
    output logic [1:0]              m_status
);

    logic                  busy_reg;
    logic                  busy_next;
    func_t                 func_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [VALUE_W-1:0]    m_result_value_reg;
    logic                  m_found_reg;
    logic [POS_W-1:0]      m_position_reg;
    logic [CNT_W-1:0]      m_entry_count_reg;
    status_t               m_status_reg;

    cell_ctrl_t            ctrl;
    logic                  accept;
    logic                  commit;
    logic                  full;
    logic                  empty;
    logic                  found;
    logic                  matched;
    logic [POS_W-1:0]      position;
    logic [VALUE_W-1:0]    result_value;
    status_t               status;

    logic [DEPTH-1:0]      occ;
    logic [DEPTH:0]        hit;
    logic [DEPTH-1:0]      first;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    assign accept  = s_valid && s_ready;
    assign commit  = busy_reg && (!m_valid_reg || m_ready);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign found   = hit[DEPTH];
    assign matched = found && (func_reg inside {FUNC_SEARCH, FUNC_REMOVE});
    assign hit[0]  = 1'b0;

    assign ctrl.cmp_en = accept;
    assign ctrl.push   = commit && (func_reg == FUNC_PUSH) && !full;
    assign ctrl.pop    = commit && (func_reg == FUNC_POP) && !empty;
    assign ctrl.remove = commit && (func_reg == FUNC_REMOVE) && found;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] above;
        logic [DATA_WIDTH-1:0] below;

        assign occ[i] = (count_reg > CNT_W'(i));

        if (i == 0) begin : g_top
            assign above = key_reg;
        end else begin : g_mid
            assign above = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_bottom
            assign below = cell_data[i];
        end else begin : g_upper
            assign below = cell_data[i+1];
        end

        sws_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cmp_key    (s_value[DATA_WIDTH-1:0]),
            .occupied   (occ[i]),
            .data_above (above),
            .data_below (below),
            .hit_in     (hit[i]),
            .hit_out    (hit[i+1]),
            .first      (first[i]),
            .data       (cell_data[i])
        );
    end

    always_comb begin
        position = '0;
        for (int i = 0; i < DEPTH; i++) begin
            position = position | (first[i] ? POS_W'(i) : '0);
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        result_value = '0;
        status       = ST_OK;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (commit) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
            case (func_reg)
                FUNC_PUSH: begin
                    if (full) begin
                        status = ST_FULL;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                end
                FUNC_POP: begin
                    if (empty) begin
                        status = ST_EMPTY;
                    end else begin
                        count_next   = count_reg - 1'b1;
                        result_value = VALUE_W'(signed'(cell_data[0]));
                    end
                end
                FUNC_SEARCH: begin
                    if (!found) begin
                        status = ST_NOTFOUND;
                    end
                end
                FUNC_REMOVE: begin
                    if (!found) begin
                        status = ST_NOTFOUND;
                    end else begin
                        count_next = count_reg - 1'b1;
                    end
                end
                default: begin
                    status = ST_OK;
                end
            endcase
        end
        if (accept) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= func_t'(s_func);
            key_reg  <= s_value[DATA_WIDTH-1:0];
        end
        if (commit) begin
            m_result_value_reg <= result_value;
            m_found_reg        <= matched;
            m_position_reg     <= matched ? position : '0;
            m_entry_count_reg  <= count_next;
            m_status_reg       <= status;
        end
    end

    assign s_ready        = !busy_reg;
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_found        = m_found_reg;
    assign m_position     = m_position_reg;
    assign m_entry_count  = m_entry_count_reg;
    assign m_status       = m_status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the stack depth.");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> busy_reg)
        else $error("Accepted beat did not start processing.");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Push did not raise the entry count by one.");

    a_first_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> $onehot0(first))
        else $error("More than one cell claims the first match.");

    a_found_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_found_reg) |-> (CNT_W'(m_position_reg) <= m_entry_count_reg))
        else $error("Match position lies beyond the stack contents.");
`endif

endmodule

`default_nettype wire

// ===== hdl/sws_cell.sv =====
// One storage cell of the stack chain; cell 0 is the top of the stack.
// Holds a word, compares it with the key and shifts with its neighbours.
// Depends on sws_pkg.
`default_nettype none

module sws_cell
    import sws_pkg::*;
(
    input  wire logic                  aclk,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic [DATA_WIDTH-1:0] cmp_key,
    input  wire logic                  occupied,
    input  wire logic [DATA_WIDTH-1:0] data_above,
    input  wire logic [DATA_WIDTH-1:0] data_below,
    input  wire logic                  hit_in,
    output logic                       hit_out,
    output logic                       first,
    output logic [DATA_WIDTH-1:0]      data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  match_reg;

    assign hit_out = hit_in | match_reg;
    assign first   = match_reg & ~hit_in;
    assign data    = data_reg;

    always_comb begin
        data_next = data_reg;
        if (ctrl.push) begin
            data_next = data_above;
        end else if (ctrl.pop || (ctrl.remove && hit_out)) begin
            data_next = data_below;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (ctrl.cmp_en) begin
            match_reg <= occupied && (data_reg == cmp_key);
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for stack_with_search_and_remove: push, pop, search and remove
// beats go in on the s_ channel and are checked on the m_ channel against a local stack.
// Depends on sws_pkg and the RTL under hdl.
`timescale 1ns / 100ps

module tb;
    import sws_pkg::*;

    localparam int STALL_LIMIT    = 2000;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_TARGET  = 1950;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        func_t       func;
        logic [31:0] value;
        idle_mode_t  idle_mode;
        bit          hold;
        bit          drain_first;
    } stack_op_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        found;
        logic [3:0]  position;
        logic [4:0]  entry_count;
        status_t     status;
    } stack_reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = FUNC_PUSH;
    logic [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_result_value;
    logic        m_found;
    logic [3:0]  m_position;
    logic [4:0]  m_entry_count;
    logic [1:0]  m_status;

    stack_op_t    queued_ops[$];
    stack_reply_t predicted_replies[$];
    logic [31:0]  model_words[DEPTH];
    int           model_fill = 0;
    idle_mode_t   idle_mode = IDLE_NONE;
    logic         hold_req = 1'b0;
    int           holdoff_left = 0;
    int           stall_cycles = 0;
    int           mismatches = 0;
    int           ops_accepted = 0;
    int           replies_seen = 0;
    int           status_seen[4] = '{0, 0, 0, 0};
    int           matches_seen = 0;

    stack_with_search_and_remove uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_found        (m_found),
        .m_position     (m_position),
        .m_entry_count  (m_entry_count),
        .m_status       (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic stack_reply_t apply_stack_op(func_t f, logic [31:0] v);
        stack_reply_t r;
        int hit;
        r = '{result_value: '0, found: 1'b0, position: '0, entry_count: '0, status: ST_OK};
        hit = -1;
        if (f == FUNC_SEARCH || f == FUNC_REMOVE) begin
            for (int i = model_fill - 1; i >= 0 && hit < 0; i--) begin
                if (model_words[i] == v) begin
                    hit = i;
                end
            end
        end
        case (f)
            FUNC_PUSH: begin
                if (model_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    model_words[model_fill] = v;
                    model_fill++;
                end
            end
            FUNC_POP: begin
                if (model_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    model_fill--;
                    r.result_value = model_words[model_fill];
                end
            end
            default: begin
                if (hit < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.found = 1'b1;
                    r.position = 4'(model_fill - 1 - hit);
                    if (f == FUNC_REMOVE) begin
                        for (int k = hit; k + 1 < model_fill; k++) begin
                            model_words[k] = model_words[k + 1];
                        end
                        model_fill--;
                    end
                end
            end
        endcase
        r.entry_count = 5'(model_fill);
        return r;
    endfunction

    function automatic void add_op(func_t f, logic [31:0] v, idle_mode_t m, bit hold,
                                   bit drain);
        stack_op_t op;
        op.func = f;
        op.value = v;
        op.idle_mode = m;
        op.hold = hold;
        op.drain_first = drain;
        queued_ops.push_back(op);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("reply %0d: %s expected %0h, got %0h", replies_seen, what, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin : drive_ops
        stack_op_t nxt;
        bit offer;
        bit hold_now;
        hold_now = 1'b0;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_func <= FUNC_PUSH;
            s_value <= '0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_replies.push_back(apply_stack_op(func_t'(s_func), s_value));
                ops_accepted++;
            end
            if (!s_valid || s_ready) begin
                offer = 1'b0;
                if (queued_ops.size() > 0) begin
                    nxt = queued_ops[0];
                    if (nxt.drain_first && predicted_replies.size() > 0) begin
                        offer = 1'b0;
                    end else if ((nxt.idle_mode == IDLE_SENDER && $urandom_range(99) < 67) ||
                                 (nxt.idle_mode == IDLE_BOTH && $urandom_range(99) < 16)) begin
                        offer = 1'b0;
                    end else begin
                        offer = 1'b1;
                    end
                end
                if (offer) begin
                    void'(queued_ops.pop_front());
                    s_valid <= 1'b1;
                    s_func <= nxt.func;
                    s_value <= nxt.value;
                    idle_mode <= nxt.idle_mode;
                    hold_now = nxt.hold;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
        hold_req <= hold_now;
    end

    always @(posedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_ready <= 1'b0;
            holdoff_left <= 0;
        end else if (hold_req) begin
            m_ready <= 1'b0;
            holdoff_left <= HOLDOFF_CYCLES;
        end else if (holdoff_left > 0) begin
            m_ready <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else begin
            m_ready <= !((idle_mode == IDLE_RECEIVER && $urandom_range(99) < 67) ||
                         (idle_mode == IDLE_BOTH && $urandom_range(99) < 16));
        end
    end

    always @(posedge aclk) begin : check_replies
        stack_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_replies.size() == 0) begin
                report_mismatch("reply with nothing outstanding, status", '0, 32'(m_status));
            end else begin
                want = predicted_replies.pop_front();
                if (want.result_value !== m_result_value) begin
                    report_mismatch("result_value", want.result_value, m_result_value);
                end
                if (want.found !== m_found) begin
                    report_mismatch("found", 32'(want.found), 32'(m_found));
                end
                if (want.position !== m_position) begin
                    report_mismatch("position", 32'(want.position), 32'(m_position));
                end
                if (want.entry_count !== m_entry_count) begin
                    report_mismatch("entry_count", 32'(want.entry_count), 32'(m_entry_count));
                end
                if (want.status !== m_status) begin
                    report_mismatch("status", 32'(want.status), 32'(m_status));
                end
                status_seen[want.status]++;
                if (want.found) begin
                    matches_seen++;
                end
            end
            replies_seen++;
        end
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else if (s_valid || predicted_replies.size() > 0) begin
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                    $display("stack_with_search_and_remove: mismatch");
                    $finish;
                end else begin
                    stall_cycles <= stall_cycles + 1;
                end
            end
        end
    end

    initial begin : run_test
        logic [31:0] pool[8];
        int seg_len;
        int seg_no;
        int bias;
        int roll;
        int p_push;
        int p_pop;
        int p_search;
        func_t f;
        logic [31:0] v;
        idle_mode_t m;

        // Empty stack first, then extremes, duplicates and removal of the only entry.
        add_op(FUNC_POP, 32'h0, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_SEARCH, 32'h0, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_REMOVE, 32'hffff_ffff, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_PUSH, 32'h7fff_ffff, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_PUSH, 32'h8000_0000, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_SEARCH, 32'h7fff_ffff, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_SEARCH, 32'h1234_5678, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_REMOVE, 32'h8000_0000, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_REMOVE, 32'h7fff_ffff, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_PUSH, 32'hffff_ffff, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_PUSH, 32'h0, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_PUSH, 32'hffff_ffff, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_SEARCH, 32'h0, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_REMOVE, 32'hffff_ffff, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_REMOVE, 32'hffff_ffff, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_POP, 32'h0, IDLE_NONE, 1'b0, 1'b0);
        add_op(FUNC_POP, 32'h0, IDLE_NONE, 1'b0, 1'b0);

        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7fff_ffff;
        pool[2] = 32'h0;
        pool[3] = 32'hffff_ffff;
        seg_no = 0;
        while (queued_ops.size() < RANDOM_TARGET) begin
            for (int i = 4; i < 8; i++) begin
                pool[i] = $urandom;
            end
            seg_len = $urandom_range(60, 20);
            bias = $urandom_range(3);
            case (bias)
                0: begin p_push = 85; p_pop = 3;  p_search = 6;  end
                1: begin p_push = 15; p_pop = 55; p_search = 15; end
                2: begin p_push = 30; p_pop = 20; p_search = 25; end
                default: begin p_push = 40; p_pop = 10; p_search = 25; end
            endcase
            m = idle_mode_t'(seg_no % 4);
            for (int n = 0; n < seg_len; n++) begin
                roll = $urandom_range(99);
                if (roll < p_push) begin
                    f = FUNC_PUSH;
                end else if (roll < p_push + p_pop) begin
                    f = FUNC_POP;
                end else if (roll < p_push + p_pop + p_search) begin
                    f = FUNC_SEARCH;
                end else begin
                    f = FUNC_REMOVE;
                end
                v = ($urandom_range(9) < 7) ? pool[$urandom_range(7)] : 32'($urandom);
                add_op(f, v, m, n == 0 && (seg_no == 4 || seg_no == 20),
                       n == 0 && seg_no % 7 == 0);
            end
            seg_no++;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (queued_ops.size() != 0 || s_valid || predicted_replies.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d operations over %0d traffic segments, %0d replies checked, %0d matches",
                 ops_accepted, seg_no, replies_seen, matches_seen);
        $display("statuses: ok %0d, full %0d, empty %0d, not found %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_NOTFOUND]);
        if (mismatches == 0) begin
            $display("stack_with_search_and_remove: match");
        end else begin
            $display("stack_with_search_and_remove: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sws_pkg.sv
hdl/sws_cell.sv
hdl/stack_with_search_and_remove.sv
sim/tb.sv
